/* hw/rtl/bgar_pkg.sv */
`default_nettype none

package bgar_pkg;

	// Number of buttons in the group; ids at or above it are ignored.
	localparam int NUM_BUTTONS = 32;

	localparam logic [32:0] ID_MASK_WIDE = (33'd1 << NUM_BUTTONS) - 33'd1;
	localparam logic [31:0] ID_MASK      = ID_MASK_WIDE[31:0];

	// Event kinds.
	localparam logic [1:0] KIND_DOWN   = 2'd0;
	localparam logic [1:0] KIND_REPEAT = 2'd1;
	localparam logic [1:0] KIND_UP     = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENABLE            = 2'd0;
	localparam logic [1:0] CFG_SLOW_PERIOD_MS    = 2'd1;
	localparam logic [1:0] CFG_SLOW_REPEAT_COUNT = 2'd2;
	localparam logic [1:0] CFG_FAST_PERIOD_MS    = 2'd3;

	localparam logic [15:0] SLOW_PERIOD_RESET = 16'd500;
	localparam logic [7:0]  SLOW_COUNT_RESET  = 8'd4;
	localparam logic [15:0] FAST_PERIOD_RESET = 16'd100;
	localparam logic [7:0]  COUNT_MAX         = 8'd255;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [31:0] button_levels;
		logic [31:0] button_changed;
	} in_beat_t;

	typedef struct packed {
		logic        event_valid;
		logic [1:0]  event_kind;
		logic [4:0]  button_id;
		logic [31:0] press_flags;
	} out_beat_t;

	typedef struct packed {
		logic        enable;
		logic [15:0] slow_period_ms;
		logic [7:0]  slow_repeat_count;
		logic [15:0] fast_period_ms;
	} cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/button_group_auto_repeat_unit.sv */
`default_nettype none

// Typematic auto-repeat for a group of push buttons, of which one is held at a
// time. Each input beat is one poll: the millisecond time, the button levels and
// the mask of buttons that changed. Every poll yields exactly one output beat,
// carrying the masked button levels and, when an event is due, a DOWN, REPEAT or
// UP event for the held button. The block takes one poll per clock cycle while
// the output side is ready; each poll passes through two registers, the input
// register and then the output register; the held-button state is updated as
// the poll moves from the first to the second, so consecutive polls see each
// other's effect in order. Sustained rate is one beat per cycle whenever the
// output side is ready. Configuration is written through a plain write port and
// must only change while no poll is in flight.
module button_group_auto_repeat_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bgar_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bgar_pkg::out_beat_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import bgar_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	// Input stage.
	logic     valid_s1;
	in_beat_t data_s1;

	// Output stage.
	logic      valid_s2;
	out_beat_t data_s2;

	out_beat_t result;
	logic      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.slow_period_ms    <= SLOW_PERIOD_RESET;
			cfg_q.slow_repeat_count <= SLOW_COUNT_RESET;
			cfg_q.fast_period_ms    <= FAST_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:            cfg_q.enable            <= cfg_data[0];
				CFG_SLOW_PERIOD_MS:    cfg_q.slow_period_ms    <= cfg_data;
				CFG_SLOW_REPEAT_COUNT: cfg_q.slow_repeat_count <= cfg_data[7:0];
				CFG_FAST_PERIOD_MS:    cfg_q.fast_period_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The poll in the input stage moves on when the output register is free
	// or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	bgar_event_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (data_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

/* hw/rtl/bgar_event_core.sv */
`default_nettype none

module bgar_event_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire bgar_pkg::in_beat_t beat,
	input  wire bgar_pkg::cfg_t     cfg,
	output bgar_pkg::out_beat_t     result
);
	import bgar_pkg::*;

	logic        held_valid_q;
	logic [4:0]  held_id_q;
	logic [31:0] repeat_deadline_q;
	logic [7:0]  repeat_count_q;

	logic [31:0] levels;
	logic [31:0] changed;
	logic [31:0] rising;
	logic [31:0] since_deadline;
	logic        released;
	logic        due;
	logic        found;
	logic [4:0]  first_id;
	logic [7:0]  count_next;
	logic [15:0] rearm_period;
	logic [31:0] slow_deadline;
	logic [31:0] rearm_deadline;
	logic        do_down;
	logic        do_up;
	logic        do_repeat;

	assign levels         = beat.button_levels & ID_MASK;
	assign changed        = beat.button_changed & ID_MASK;
	assign rising         = levels & changed;
	assign released       = changed[held_id_q] & ~levels[held_id_q];
	assign since_deadline = beat.now_ms - repeat_deadline_q;
	assign due            = ~since_deadline[31];

	// Lowest-numbered rising button wins.
	always_comb begin
		found    = 1'b0;
		first_id = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (rising[i]) begin
				found    = 1'b1;
				first_id = 5'(i);
			end
		end
	end

	assign count_next     = (repeat_count_q != COUNT_MAX) ? repeat_count_q + 8'd1 : repeat_count_q;
	assign rearm_period   = (count_next < cfg.slow_repeat_count) ? cfg.slow_period_ms
	                                                              : cfg.fast_period_ms;
	assign slow_deadline  = beat.now_ms + {16'd0, cfg.slow_period_ms};
	assign rearm_deadline = beat.now_ms + {16'd0, rearm_period};

	assign do_down   = cfg.enable & ~held_valid_q & found;
	assign do_up     = cfg.enable & held_valid_q & released;
	assign do_repeat = cfg.enable & held_valid_q & ~released & due;

	always_comb begin
		result             = '0;
		result.press_flags = levels;
		if (do_down) begin
			result.event_valid = 1'b1;
			result.event_kind  = KIND_DOWN;
			result.button_id   = first_id;
		end else if (do_up) begin
			result.event_valid = 1'b1;
			result.event_kind  = KIND_UP;
			result.button_id   = held_id_q;
		end else if (do_repeat) begin
			result.event_valid = 1'b1;
			result.event_kind  = KIND_REPEAT;
			result.button_id   = held_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q      <= 1'b0;
			held_id_q         <= 5'd0;
			repeat_deadline_q <= 32'd0;
			repeat_count_q    <= 8'd0;
		end else if (step) begin
			if (do_down) begin
				held_valid_q      <= 1'b1;
				held_id_q         <= first_id;
				repeat_deadline_q <= slow_deadline;
				repeat_count_q    <= 8'd0;
			end else if (do_up) begin
				held_valid_q <= 1'b0;
			end else if (do_repeat) begin
				repeat_count_q    <= count_next;
				repeat_deadline_q <= rearm_deadline;
			end
		end
	end

	a_down_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		result.event_valid && result.event_kind == KIND_DOWN |-> !held_valid_q)
		else $error("down event while a button is held");

	a_held_id_on_repeat_up: assert property (@(posedge clk) disable iff (!arst_n)
		result.event_valid && result.event_kind != KIND_DOWN |-> result.button_id == held_id_q)
		else $error("repeat or up event names a button other than the held one");

	a_down_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && do_down |=> held_valid_q && held_id_q == $past(first_id)
		&& repeat_count_q == 8'd0)
		else $error("down event did not capture the held button");

	a_disabled_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg.enable |=> $stable(held_valid_q) && $stable(repeat_count_q)
		&& $stable(repeat_deadline_q))
		else $error("state changed while disabled");

endmodule

`default_nettype wire
